FILE: rtl/toroidal_life_generation_engine_defines.svh
// Assertion macros shared by the toroidal Life engine RTL.
// Depends on nothing; users must have clock and reset in scope.
`ifndef TOROIDAL_LIFE_GENERATION_ENGINE_DEFINES_SVH
`define TOROIDAL_LIFE_GENERATION_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define TLGE_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("tlge assertion failed");
`define TLGE_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tlge assertion failed");
`else
`define TLGE_ASSERT(lbl, prop)
`define TLGE_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

FILE: rtl/tlge_pkg.sv
// Shared constants, mode codes and controller/datapath structs.
// Depends on nothing.
package tlge_pkg;

   localparam int DEF_GRID_WIDTH  = 64;
   localparam int DEF_GRID_HEIGHT = 64;
   localparam int WORD_BITS       = 32;
   localparam int DEF_RAM_DEPTH   = 256;

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_STEP  = 2'd2;

   typedef struct packed {
      logic clear;
      logic wr_req;
      logic rd_req;
      logic start;
      logic load_zero;
      logic load_read;
      logic load_step;
   } tlge_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic step_done;
   } tlge_status_type;

endpackage

FILE: rtl/tlge_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on tlge_pkg for default sizes.
module tlge_ram
   import tlge_pkg::*;
#(
   parameter int WIDTH = WORD_BITS,
   parameter int DEPTH = DEF_RAM_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/tlge_ctrl.sv
// Controller state machine: handshakes, clearing pass, step sequencing.
// Depends on tlge_pkg and the defines header.
`include "toroidal_life_generation_engine_defines.svh"
module tlge_ctrl
   import tlge_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [1:0]      req_mode,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output tlge_cmd_type    cmd,
   input  tlge_status_type st
);

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_STEP} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (st.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               case (req_mode)
                  MODE_WRITE: begin
                     cmd.wr_req    = 1'b1;
                     cmd.load_zero = 1'b1;
                     rsp_valid_in  = 1'b1;
                  end
                  MODE_READ: begin
                     cmd.rd_req = 1'b1;
                     state_in   = ST_READ;
                  end
                  MODE_STEP: begin
                     cmd.start = 1'b1;
                     state_in  = ST_STEP;
                  end
                  default: begin
                     cmd.load_zero = 1'b1;
                     rsp_valid_in  = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            cmd.load_read = 1'b1;
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_STEP: begin
            if (st.step_done) begin
               cmd.load_step = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `TLGE_ASSERT_IMP(a_load_slot_free, cmd.load_read || cmd.load_step, !rsp_valid_ff)
   `TLGE_ASSERT_IMP(a_ready_only_idle, req_ready, state_ff == ST_IDLE)

endmodule

FILE: rtl/tlge_datapath.sv
// Datapath: banked grid RAM, neighbor sweep pipeline, result registers.
// Depends on tlge_pkg, tlge_ram and the defines header.
`include "toroidal_life_generation_engine_defines.svh"
module tlge_datapath
   import tlge_pkg::*;
#(
   parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
   input  logic            clock,
   input  logic            reset,
   input  tlge_cmd_type    cmd,
   output tlge_status_type st,
   input  logic [6:0]      req_word_index,
   input  logic [31:0]     req_write_data,
   output logic [31:0]     rsp_read_data,
   output logic            rsp_any_changed,
   output logic            rsp_any_alive,
   output logic            rsp_keep_running
);

   localparam int NUM_CELLS = GRID_WIDTH * GRID_HEIGHT;
   localparam int NUM_WORDS = (NUM_CELLS + 31) / 32;
   localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int RAM_AW    = WORD_AW + 1;
   localparam int RAM_DEPTH = 2 ** RAM_AW;
   localparam int CELL_W    = $clog2(NUM_CELLS);
   localparam int XW        = $clog2(GRID_WIDTH);
   localparam int YW        = $clog2(GRID_HEIGHT);
   localparam int TAIL      = NUM_CELLS % 32;
   localparam logic [31:0] LAST_MASK =
      (TAIL == 0) ? 32'hFFFF_FFFF : ((32'd1 << TAIL) - 32'd1);
   localparam logic [XW-1:0]     X_MAX     = XW'(GRID_WIDTH - 1);
   localparam logic [YW-1:0]     Y_MAX     = YW'(GRID_HEIGHT - 1);
   localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(NUM_CELLS - 1);

   logic              bank_ff;
   logic [RAM_AW-1:0] clr_ff;

   // sweep issue counters
   logic          iss_ff;
   logic [XW-1:0] x_ff;
   logic [YW-1:0] y_ff;
   logic [3:0]    k_ff;

   // address stage and data stage
   logic               a_vld_ff, a_last_ff;
   logic [WORD_AW-1:0] a_word_ff;
   logic [4:0]         a_bit_ff;
   logic               b_vld_ff, b_last_ff;
   logic [4:0]         b_bit_ff;

   // per-cell and per-generation accumulation
   logic [3:0]        cnt_ff;
   logic [CELL_W-1:0] oc_ff;
   logic [31:0]       acc_ff;
   logic              chg_acc_ff, alv_acc_ff, done_ff;
   logic              rd_ok_ff;

   logic [31:0] read_data_ff;
   logic        changed_ff, alive_ff, keep_ff;

   logic [XW-1:0]      xm, xp, xn;
   logic [YW-1:0]      ym, yp, yn;
   logic [CELL_W-1:0]  cell_idx;
   logic               iss_last;
   logic [31:0]        rd_data;
   logic               bitv, nv, cell_done, word_full, step_wr;
   logic [31:0]        acc_next;
   logic               idx_ok;
   logic [WORD_AW-1:0] idx_word;
   logic [31:0]        wr_mask;
   logic               ram_wr_en;
   logic [RAM_AW-1:0]  ram_wr_addr, ram_rd_addr;
   logic [31:0]        ram_wr_data;

   assign xm = (x_ff == '0) ? X_MAX : x_ff - 1'b1;
   assign xp = (x_ff == X_MAX) ? '0 : x_ff + 1'b1;
   assign ym = (y_ff == '0) ? Y_MAX : y_ff - 1'b1;
   assign yp = (y_ff == Y_MAX) ? '0 : y_ff + 1'b1;

   // eight neighbors first, the center cell last
   always_comb begin
      case (k_ff)
         4'd0:    begin xn = xm;   yn = ym;   end
         4'd1:    begin xn = x_ff; yn = ym;   end
         4'd2:    begin xn = xp;   yn = ym;   end
         4'd3:    begin xn = xm;   yn = y_ff; end
         4'd4:    begin xn = xp;   yn = y_ff; end
         4'd5:    begin xn = xm;   yn = yp;   end
         4'd6:    begin xn = x_ff; yn = yp;   end
         4'd7:    begin xn = xp;   yn = yp;   end
         default: begin xn = x_ff; yn = y_ff; end
      endcase
   end

   assign cell_idx = CELL_W'(yn) * CELL_W'(GRID_WIDTH) + CELL_W'(xn);
   assign iss_last = (k_ff == 4'd8) && (x_ff == X_MAX) && (y_ff == Y_MAX);

   assign bitv      = rd_data[b_bit_ff];
   assign nv        = bitv ? ((cnt_ff == 4'd2) || (cnt_ff == 4'd3)) : (cnt_ff == 4'd3);
   assign cell_done = b_vld_ff && b_last_ff;
   assign acc_next  = acc_ff | (32'(nv) << 5'(oc_ff));
   assign word_full = (5'(oc_ff) == 5'd31) || (oc_ff == LAST_CELL);
   assign step_wr   = cell_done && word_full;

   assign idx_ok   = 32'(req_word_index) < 32'(NUM_WORDS);
   assign idx_word = WORD_AW'(req_word_index);
   assign wr_mask  = (32'(req_word_index) == 32'(NUM_WORDS - 1)) ? LAST_MASK : 32'hFFFF_FFFF;

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = clr_ff;
      ram_wr_data = '0;
      if (cmd.clear) begin
         ram_wr_en = 1'b1;
      end else if (step_wr) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = {~bank_ff, WORD_AW'(oc_ff >> 5)};
         ram_wr_data = acc_next;
      end else if (cmd.wr_req && idx_ok) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = {bank_ff, idx_word};
         ram_wr_data = req_write_data & wr_mask;
      end
   end

   assign ram_rd_addr = cmd.rd_req ? {bank_ff, idx_word} : {bank_ff, a_word_ff};

   tlge_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff  <= 1'b0;
         clr_ff   <= '0;
         iss_ff   <= 1'b0;
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         if (cmd.clear) begin
            clr_ff <= clr_ff + 1'b1;
         end
         // issue one read per cycle, for a neighbor or the center cell
         a_vld_ff  <= iss_ff;
         a_word_ff <= WORD_AW'(cell_idx >> 5);
         a_bit_ff  <= 5'(cell_idx);
         a_last_ff <= (k_ff == 4'd8);
         if (cmd.start) begin
            iss_ff <= 1'b1;
            x_ff   <= '0;
            y_ff   <= '0;
            k_ff   <= '0;
         end else if (iss_ff) begin
            if (iss_last) begin
               iss_ff <= 1'b0;
            end
            if (k_ff == 4'd8) begin
               k_ff <= '0;
               if (x_ff == X_MAX) begin
                  x_ff <= '0;
                  y_ff <= yp;
               end else begin
                  x_ff <= xp;
               end
            end else begin
               k_ff <= k_ff + 1'b1;
            end
         end
         b_vld_ff  <= a_vld_ff;
         b_bit_ff  <= a_bit_ff;
         b_last_ff <= a_last_ff;
         if (b_vld_ff) begin
            cnt_ff <= b_last_ff ? 4'd0 : cnt_ff + 4'(bitv);
         end
         done_ff <= cell_done && (oc_ff == LAST_CELL);
         if (cmd.load_step) begin
            bank_ff <= ~bank_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         oc_ff      <= '0;
         acc_ff     <= '0;
         chg_acc_ff <= 1'b0;
         alv_acc_ff <= 1'b0;
      end else if (cell_done) begin
         oc_ff      <= oc_ff + 1'b1;
         acc_ff     <= word_full ? 32'd0 : acc_next;
         chg_acc_ff <= chg_acc_ff | (nv != bitv);
         alv_acc_ff <= alv_acc_ff | nv;
      end
      if (cmd.rd_req) begin
         rd_ok_ff <= idx_ok;
      end
      if (cmd.load_zero) begin
         read_data_ff <= '0;
         changed_ff   <= 1'b0;
         alive_ff     <= 1'b0;
         keep_ff      <= 1'b0;
      end else if (cmd.load_read) begin
         read_data_ff <= rd_ok_ff ? rd_data : 32'd0;
         changed_ff   <= 1'b0;
         alive_ff     <= 1'b0;
         keep_ff      <= 1'b0;
      end else if (cmd.load_step) begin
         read_data_ff <= '0;
         changed_ff   <= chg_acc_ff;
         alive_ff     <= alv_acc_ff;
         keep_ff      <= chg_acc_ff | alv_acc_ff;
      end
   end

   assign st.clear_last = (clr_ff == '1);
   assign st.step_done  = done_ff;

   assign rsp_read_data    = read_data_ff;
   assign rsp_any_changed  = changed_ff;
   assign rsp_any_alive    = alive_ff;
   assign rsp_keep_running = keep_ff;

   `TLGE_ASSERT_IMP(a_done_drained, st.step_done, !iss_ff && !a_vld_ff && !b_vld_ff)
   `TLGE_ASSERT(a_count_range, cnt_ff <= 4'd8)

endmodule

FILE: rtl/toroidal_life_generation_engine.sv
// Top level of the toroidal B3/S23 Life engine.
// Depends on tlge_pkg, tlge_ctrl and tlge_datapath.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_mode, req_word_index, req_write_data
//   rsp      out        rsp_valid/rsp_ready    rsp_read_data, rsp_any_changed,
//                                              rsp_any_alive, rsp_keep_running
//
// Write and unused-mode items are answered straight from idle; a read first
// passes through one RAM read. A step makes one RAM read per neighbor and
// per center cell through the single read port.
// After reset a clearing pass writes 2*2^ceil(log2(words)) RAM entries, one a
// cycle (256 for 64x64), and no item is taken meanwhile.
// The result sits in an output register; the next item is taken while it
// waits only if it is taken in the same cycle.
module toroidal_life_generation_engine
   import tlge_pkg::*;
#(
   parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [6:0]  req_word_index,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic        rsp_any_changed,
   output logic        rsp_any_alive,
   output logic        rsp_keep_running
);

   tlge_cmd_type    cmd;
   tlge_status_type st;

   // sequence clearing, word access and generation sweeps
   tlge_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .st        (st)
   );

   // hold both banks, sweep neighbors, hold the result item
   tlge_datapath #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_word_index   (req_word_index),
      .req_write_data   (req_write_data),
      .rsp_read_data    (rsp_read_data),
      .rsp_any_changed  (rsp_any_changed),
      .rsp_any_alive    (rsp_any_alive),
      .rsp_keep_running (rsp_keep_running)
   );

endmodule
